// ----- rtl/core/cse_pkg.sv -----
// Package for the calibration store engine: command/result payload types,
// function and status codes, record layout constants. No dependencies.
package cse_pkg;

    localparam logic [1:0] FUNC_ZERO     = 2'd0;
    localparam logic [1:0] FUNC_GAIN     = 2'd1;
    localparam logic [1:0] FUNC_RECORD   = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_ACCEPTED = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [2:0] REG_TR_CURRENT = 3'd0;
    localparam logic [2:0] REG_TR_MID     = 3'd1;
    localparam logic [2:0] REG_TR_VOLTAGE = 3'd2;
    localparam logic [2:0] REG_BASE_GAIN  = 3'd3;
    localparam logic [2:0] REG_BASE_ZERO  = 3'd4;
    localparam logic [2:0] REG_WIN_LOW    = 3'd5;
    localparam logic [2:0] REG_WIN_HIGH   = 3'd6;

    localparam logic [15:0] GAIN_SCALE = 16'd10000;
    localparam logic [15:0] MARK_WORD  = 16'hFFFF;

    // ceil(2^24 * 85/100) and ceil(2^24 * 115/100): exact floors for any 16-bit base
    localparam logic [24:0] LO_WIN_RECIP = 25'd14260634;
    localparam logic [24:0] HI_WIN_RECIP = 25'd19293799;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  channel;
        logic [15:0] sample;
        logic [31:0] measured_value;
        logic [4:0]  word_index;
        logic [15:0] stored_word;
        logic        last_item;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_valid;
        logic [4:0]  write_index;
        logic [15:0] write_word;
        logic        last_result;
    } t_result;

    // Divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/cse_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module cse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/cse_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on cse_pkg.
module cse_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cse_pkg::t_div_req  i_req,
    output cse_pkg::t_div_rsp  o_rsp
);
    import cse_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem[31:0], r_quo[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial[32]) begin
                n_rem = {r_rem[31:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[30:0], 1'b1};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && !$past(i_req.start) |-> $past(r_cnt) == 6'd31)
        else $error("divider stopped early");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
`endif
endmodule

// ----- rtl/core/calibration_store_engine_unit.sv -----
// Top level of the calibration store engine: command sequencer, tables,
// staging RAM and serial divider. Depends on cse_pkg, cse_ram, cse_div.
//
// Usage: a command is taken when start is high and busy low. A zero sample
// or record word that is not last gives no result and leaves busy low. The
// final zero sample holds busy through its check (S_ZLAST, S_ONE), then
// through emission in S_EMIT; a failed run gives one result instead. A gain
// command holds busy for setup (S_PRE), the serial divider in S_DIV until
// its done pulse, window check and result select (S_CHK, S_ONE), then
// emission; a bad channel or a zero measurement goes straight to S_ONE for
// its failure. The final record word sweeps the staging RAM in S_SCAN,
// decides in S_DECIDE, then either sweeps again in S_LOAD to adopt the
// record (one result) or restores the defaults and emits. A success or a
// rejected record emits 2*CHANNELS+1 result words on consecutive cycles with
// o_res_valid high; failures and an accepted record give one result. The
// last result appears in the first cycle with busy low. The receiver cannot
// stall: every result is valid for exactly one cycle.
module calibration_store_engine_unit #(
    parameter int CHANNELS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cse_pkg::t_cmd       i_cmd,
    output logic                o_res_valid,
    output cse_pkg::t_result    o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import cse_pkg::*;

    localparam int RW  = 2 * CHANNELS + 1;
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW  = $clog2(RW + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_EMIT  = 4'd3;
    localparam logic [3:0] S_ONE   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_LOAD  = 4'd7;
    localparam logic [3:0] S_DEFLT = 4'd8;
    localparam logic [3:0] S_ZLAST = 4'd9;
    localparam logic [3:0] S_PRE   = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [15:0] r_tr_cur, r_tr_mid, r_tr_vol, r_base_gain, r_base_zero;
    logic [15:0] r_win_lo, r_win_hi;
    logic [15:0] r_gain [CHANNELS];
    logic [15:0] r_zero [CHANNELS];
    logic [15:0] r_cksum;
    logic        r_zfail;
    logic [4:0]  r_zcnt;
    t_cmd        r_cmd;
    logic [IW-1:0] r_idx;
    logic [15:0] r_xor;
    logic        r_marks;
    logic [1:0]  r_status;
    logic        r_out_v, n_out_v;
    t_result     r_out;
    logic        r_rd_v;
    logic [IW-1:0] r_rd_idx;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [31:0] prod;
    logic [40:0] lo_prod, hi_prod;
    logic [33:0] lo_lim, hi_lim;

    logic        ram_we;
    logic [$clog2(RW)-1:0] ram_waddr, ram_raddr;
    logic [15:0] ram_rdata;

    logic        take;
    logic        zpass;
    logic [15:0] emit_word;

    assign take        = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Staging RAM: written directly by accepted record words
    assign ram_we    = take && i_cmd.func == FUNC_RECORD && {27'd0, i_cmd.word_index} < RW;
    assign ram_waddr = i_cmd.word_index[$clog2(RW)-1:0];
    assign ram_raddr = r_idx[$clog2(RW)-1:0];

    cse_ram #(.WIDTH(16), .DEPTH(RW)) u_stage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.stored_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        unique case (r_cmd.channel)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: prod = 32'(r_tr_cur) * 32'(GAIN_SCALE);
            4'd6:    prod = 32'(r_tr_mid) * 32'(GAIN_SCALE);
            default: prod = 32'(r_tr_vol) * 32'(GAIN_SCALE);
        endcase
    end

    assign div_req.start    = (r_state == S_PRE);
    assign div_req.dividend = prod;
    assign div_req.divisor  = r_cmd.measured_value;

    cse_div u_div (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_req (div_req),
        .o_rsp (div_rsp)
    );

    // Window limits: floor(b*85/100), floor(b*115/100) by reciprocal multiplication
    assign lo_prod = {25'd0, r_base_gain} * {16'd0, LO_WIN_RECIP};
    assign hi_prod = {25'd0, r_base_gain} * {16'd0, HI_WIN_RECIP};
    assign lo_lim  = {17'd0, lo_prod[40:24]};
    assign hi_lim  = {17'd0, hi_prod[40:24]};

    assign zpass = !r_zfail && {1'b0, i_cmd.channel} == r_zcnt
                   && {28'd0, i_cmd.channel} < CHANNELS
                   && i_cmd.sample > r_win_lo && i_cmd.sample < r_win_hi;

    always_comb begin
        if (r_idx < IW'(CHANNELS)) begin
            emit_word = r_gain[r_idx[CW-1:0]];
        end else if (r_idx < IW'(2 * CHANNELS)) begin
            emit_word = r_zero[CW'(r_idx - IW'(CHANNELS))];
        end else begin
            emit_word = r_xor;
        end
    end

    assign n_out_v = (r_state == S_EMIT)
                     || (r_state == S_ONE && r_status != ST_OK && r_status != ST_REJECTED);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_cmd.func)
                        FUNC_ZERO:   n_state = i_cmd.last_item ? S_ZLAST : S_IDLE;
                        FUNC_GAIN:   n_state = ({28'd0, i_cmd.channel} >= CHANNELS
                                                || i_cmd.measured_value == '0)
                                                ? S_ONE : S_PRE;
                        FUNC_RECORD: n_state = i_cmd.last_item ? S_SCAN : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_PRE:    n_state = S_DIV;
            S_DIV:    n_state = div_rsp.done ? S_CHK : S_DIV;
            S_CHK:    n_state = S_ONE;
            S_ZLAST:  n_state = S_ONE;
            S_SCAN:   n_state = (r_rd_v && r_rd_idx == IW'(RW - 1)) ? S_DECIDE : S_SCAN;
            S_DECIDE: n_state = (r_xor == '0 && !r_marks) ? S_LOAD : S_DEFLT;
            S_LOAD:   n_state = (r_rd_v && r_rd_idx == IW'(RW - 1)) ? S_ONE : S_LOAD;
            S_DEFLT:  n_state = S_ONE;
            S_ONE:    n_state = (r_status == ST_OK || r_status == ST_REJECTED)
                                ? S_EMIT : S_IDLE;
            S_EMIT:   n_state = (r_idx == IW'(RW - 1)) ? S_IDLE : S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tr_cur <= 16'd1850;
            r_tr_mid <= 16'd4214;
            r_tr_vol <= 16'd4635;
            r_base_gain <= 16'd10032;
            r_base_zero <= 16'd32767;
            r_win_lo <= 16'h7320;
            r_win_hi <= 16'h8CE0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_gain[i] <= 16'd10032;
                r_zero[i] <= 16'd32767;
            end
            r_cksum <= '0;
            r_zfail <= 1'b0;
            r_zcnt  <= '0;
            r_idx   <= '0;
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_rd_v  <= (r_state == S_SCAN || r_state == S_LOAD) && r_idx != IW'(RW);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TR_CURRENT: r_tr_cur <= i_cfg_data;
                    REG_TR_MID:     r_tr_mid <= i_cfg_data;
                    REG_TR_VOLTAGE: r_tr_vol <= i_cfg_data;
                    REG_BASE_GAIN:  r_base_gain <= i_cfg_data;
                    REG_BASE_ZERO:  r_base_zero <= i_cfg_data;
                    REG_WIN_LOW:    r_win_lo <= i_cfg_data;
                    REG_WIN_HIGH:   r_win_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_xor <= '0;
                        r_marks <= 1'b0;
                        if (i_cmd.func == FUNC_ZERO) begin
                            if (zpass) begin
                                r_zero[i_cmd.channel[CW-1:0]] <= i_cmd.sample;
                                r_zcnt <= r_zcnt + 5'd1;
                            end else begin
                                r_zfail <= 1'b1;
                            end
                        end
                        if (i_cmd.func == FUNC_GAIN) begin
                            r_status <= ST_FAIL;
                        end
                    end
                end
                S_PRE, S_DIV: ;
                S_CHK: begin
                    if ({2'd0, div_rsp.quotient} > lo_lim
                        && {2'd0, div_rsp.quotient} < hi_lim) begin
                        r_gain[r_cmd.channel[CW-1:0]] <= div_rsp.quotient[15:0] + 16'd1;
                        r_status <= ST_OK;
                    end
                end
                S_ZLAST: begin
                    r_status <= (!r_zfail && r_zcnt == 5'(CHANNELS)) ? ST_OK : ST_FAIL;
                    r_zfail <= 1'b0;
                    r_zcnt  <= '0;
                end
                S_SCAN, S_LOAD: begin
                    // Address advances; data returns in the next cycle
                    if (r_idx != IW'(RW)) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    r_rd_idx <= r_idx;
                    if (r_rd_v) begin
                        r_xor <= r_xor ^ ram_rdata;
                        if (r_rd_idx < IW'(2 * CHANNELS) && ram_rdata == MARK_WORD) begin
                            r_marks <= 1'b1;
                        end
                        if (r_state == S_LOAD) begin
                            if (r_rd_idx < IW'(CHANNELS)) begin
                                r_gain[r_rd_idx[CW-1:0]] <= ram_rdata;
                            end else if (r_rd_idx < IW'(2 * CHANNELS)) begin
                                r_zero[CW'(r_rd_idx - IW'(CHANNELS))] <= ram_rdata;
                            end else begin
                                r_cksum <= ram_rdata;
                            end
                        end
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    if (r_xor == '0 && !r_marks) begin
                        r_status <= ST_ACCEPTED;
                    end else begin
                        r_status <= ST_REJECTED;
                        for (int i = 0; i < CHANNELS; i++) begin
                            r_gain[i] <= r_base_gain;
                            r_zero[i] <= r_base_zero;
                        end
                        // XOR of equal pairs cancels unless channel count is odd
                        r_cksum <= (CHANNELS % 2 == 1) ? (r_base_gain ^ r_base_zero) : 16'd0;
                    end
                end
                S_DEFLT: ;
                S_ONE: begin
                    r_idx <= '0;
                    r_xor <= '0;
                    if (r_status != ST_OK && r_status != ST_REJECTED) begin
                        r_out <= '{status: r_status, write_valid: 1'b0, write_index: '0,
                                   write_word: '0, last_result: 1'b1};
                    end
                end
                S_EMIT: begin
                    // Fold checksum while emitting; the last word carries it
                    r_out <= '{status: r_status, write_valid: 1'b1,
                               write_index: 5'(r_idx), write_word: emit_word,
                               last_result: r_idx == IW'(RW - 1)};
                    if (r_idx < IW'(2 * CHANNELS)) begin
                        r_xor <= r_xor ^ emit_word;
                    end
                    r_idx <= r_idx + IW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_result |-> busy) else $error("result outside run");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_result |-> !busy) else $error("busy after last");
    a_wv_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.write_valid |-> o_res.status == ST_OK
        || o_res.status == ST_REJECTED) else $error("write on bad status");
`endif
endmodule
